// ===== hdl/rdcw_pkg.sv =====
// Shared types and codes for the remote drive command watchdog.
// Holds the payload structs, command, mode and direction codes and config layout.
// No dependencies.
package rdcw_pkg;

  // Command codes carried in the cmd field.
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_REFRESH = 3'd1,
    CMD_LEFT    = 3'd2,
    CMD_RIGHT   = 3'd3,
    CMD_TOGGLE  = 3'd4
  } cmd_e;

  // Run modes.
  typedef enum logic [1:0] {
    RUN_IDLE  = 2'd0,
    RUN_SLEEP = 2'd1,
    RUN_DRIVE = 2'd2
  } mode_e;

  // Motor directions.
  typedef enum logic [1:0] {
    DIR_FREE    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_e;

  // Configuration register indexes.
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_SLEEP_TIMEOUT = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_TIMEOUT  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_FRONT_LED     = 2'd2;

  localparam int unsigned CfgDataW = 16;

  // Reset values of the configuration registers.
  localparam logic [15:0] SLEEP_TIMEOUT_RST = 16'd5000;
  localparam logic [15:0] IDLE_TIMEOUT_RST  = 16'd40000;
  localparam logic [7:0]  FRONT_LED_RST     = 8'd0;

  // One input beat.
  typedef struct packed {
    logic [2:0]        cmd;
    logic signed [7:0] value;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [1:0] left_direction;
    logic [7:0] left_drive;
    logic [1:0] right_direction;
    logic [7:0] right_drive;
    logic       back_left_lamp;
    logic       back_right_lamp;
    logic       front_lamp;
    logic [1:0] run_mode;
    logic       report_request;
  } out_item_t;

  // Configuration values seen by the datapath.
  typedef struct packed {
    logic [15:0] sleep_timeout_ms;
    logic [15:0] idle_timeout_ms;
    logic [7:0]  front_led_code;
  } cfg_t;

endpackage

// ===== hdl/rdcw_in_stage.sv =====
// Input register stage of the remote drive command watchdog.
// Captures one input beat and holds it until the step stage takes it.
// Depends on rdcw_pkg.
module rdcw_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rdcw_pkg::in_item_t in_data_i,
  output logic              item_valid_o,
  input  logic              item_take_i,
  output rdcw_pkg::in_item_t item_o
);

  logic               vld_q, vld_d;
  rdcw_pkg::in_item_t item_q;
  logic               accept;

  // The register is free when empty or when its beat leaves this cycle.
  assign in_stall_o = vld_q & ~item_take_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (accept) begin
      vld_d = 1'b1;
    end else if (item_take_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Payload register needs no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
  end

  assign item_valid_o = vld_q;
  assign item_o       = item_q;

endmodule

// ===== hdl/rdcw_step.sv =====
// Command step and result register of the remote drive command watchdog.
// Holds powers, mode, elapsed count, motor outputs and LED; applies one beat per cycle unless out stalls.
// Depends on rdcw_pkg.
module rdcw_step (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rdcw_pkg::cfg_t     cfg_i,
  input  logic               item_valid_i,
  output logic               item_take_o,
  input  rdcw_pkg::in_item_t item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rdcw_pkg::out_item_t out_data_o
);

  // Direction and magnitude for one stored power; -128 clamps to 127.
  function automatic logic [8:0] drive_one(input logic [7:0] power);
    logic [7:0] neg;
    logic [6:0] mag;
    rdcw_pkg::dir_e dir;
    neg = 8'd0 - power;
    if (power == 8'd0) begin
      dir = rdcw_pkg::DIR_FREE;
      mag = 7'd0;
    end else if (power[7]) begin
      dir = rdcw_pkg::DIR_REVERSE;
      mag = neg[7] ? 7'd127 : neg[6:0];
    end else begin
      dir = rdcw_pkg::DIR_FORWARD;
      mag = power[6:0];
    end
    return {dir, mag};
  endfunction

  logic [7:0]      left_power_q, left_power_d;
  logic [7:0]      right_power_q, right_power_d;
  rdcw_pkg::mode_e mode_q, mode_d;
  logic [15:0]     elapsed_q, elapsed_d;
  rdcw_pkg::dir_e  dir_l_q, dir_l_d, dir_r_q, dir_r_d;
  logic [6:0]      mag_l_q, mag_l_d, mag_r_q, mag_r_d;
  logic            led_q, led_d;
  logic            report;
  logic            enter_drive;
  logic [8:0]      drv_l, drv_r;

  logic                out_vld_q, out_vld_d;
  rdcw_pkg::out_item_t out_q, out_d;

  // The step fires when a beat waits and the result register can take it.
  assign item_take_o = item_valid_i & ~(out_vld_q & out_stall_i);

  // Command decode, then the drive watchdog check.
  always_comb begin
    left_power_d  = left_power_q;
    right_power_d = right_power_q;
    mode_d        = mode_q;
    elapsed_d     = elapsed_q;
    dir_l_d       = dir_l_q;
    dir_r_d       = dir_r_q;
    mag_l_d       = mag_l_q;
    mag_r_d       = mag_r_q;
    led_d         = led_q;
    report        = 1'b0;
    enter_drive   = 1'b0;

    case (rdcw_pkg::cmd_e'(item_i.cmd))
      rdcw_pkg::CMD_TICK: begin
        if (elapsed_q != 16'hFFFF) begin
          elapsed_d = elapsed_q + 16'd1;
        end
      end
      rdcw_pkg::CMD_REFRESH: begin
        elapsed_d = 16'd0;
        report    = 1'b1;
        if (mode_q == rdcw_pkg::RUN_SLEEP) begin
          enter_drive = 1'b1;
        end
      end
      rdcw_pkg::CMD_LEFT: begin
        left_power_d = item_i.value;
        enter_drive  = 1'b1;
      end
      rdcw_pkg::CMD_RIGHT: begin
        right_power_d = item_i.value;
        enter_drive   = 1'b1;
      end
      rdcw_pkg::CMD_TOGGLE: begin
        if (item_i.value == cfg_i.front_led_code) begin
          led_d = ~led_q;
        end
      end
      default: begin
      end
    endcase

    drv_l = drive_one(left_power_d);
    drv_r = drive_one(right_power_d);
    if (enter_drive) begin
      dir_l_d = rdcw_pkg::dir_e'(drv_l[8:7]);
      mag_l_d = drv_l[6:0];
      dir_r_d = rdcw_pkg::dir_e'(drv_r[8:7]);
      mag_r_d = drv_r[6:0];
      mode_d  = rdcw_pkg::RUN_DRIVE;
    end

    // Too long without an update stops the motors; stored powers stay.
    if (mode_d == rdcw_pkg::RUN_DRIVE) begin
      if (elapsed_d > cfg_i.idle_timeout_ms || elapsed_d > cfg_i.sleep_timeout_ms) begin
        dir_l_d = rdcw_pkg::DIR_FREE;
        mag_l_d = 7'd0;
        dir_r_d = rdcw_pkg::DIR_FREE;
        mag_r_d = 7'd0;
        mode_d  = (elapsed_d > cfg_i.idle_timeout_ms) ? rdcw_pkg::RUN_IDLE
                                                      : rdcw_pkg::RUN_SLEEP;
      end
    end
  end

  // Result beat built from the updated state.
  always_comb begin
    out_d.left_direction  = dir_l_d;
    out_d.left_drive      = {mag_l_d, 1'b0};
    out_d.right_direction = dir_r_d;
    out_d.right_drive     = {mag_r_d, 1'b0};
    out_d.back_left_lamp  = (dir_l_d == rdcw_pkg::DIR_REVERSE);
    out_d.back_right_lamp = (dir_r_d == rdcw_pkg::DIR_REVERSE);
    out_d.front_lamp      = led_d;
    out_d.run_mode        = mode_d;
    out_d.report_request  = report;
  end

  always_comb begin
    out_vld_d = out_vld_q & out_stall_i;
    if (item_take_o) begin
      out_vld_d = 1'b1;
    end
  end

  // Block state and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_power_q  <= 8'd0;
      right_power_q <= 8'd0;
      mode_q        <= rdcw_pkg::RUN_IDLE;
      elapsed_q     <= 16'd0;
      dir_l_q       <= rdcw_pkg::DIR_FREE;
      dir_r_q       <= rdcw_pkg::DIR_FREE;
      mag_l_q       <= 7'd0;
      mag_r_q       <= 7'd0;
      led_q         <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      if (item_take_o) begin
        left_power_q  <= left_power_d;
        right_power_q <= right_power_d;
        mode_q        <= mode_d;
        elapsed_q     <= elapsed_d;
        dir_l_q       <= dir_l_d;
        dir_r_q       <= dir_r_d;
        mag_l_q       <= mag_l_d;
        mag_r_q       <= mag_r_d;
        led_q         <= led_d;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (item_take_o) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ===== hdl/remote_drive_command_watchdog.sv =====
// Top level of the remote drive command watchdog.
// Holds the configuration registers and joins the input stage and the step stage.
// Depends on rdcw_pkg, rdcw_in_stage and rdcw_step.
//
//   Channel  Direction  Handshake              Payload
//   in       input      in_valid_i/in_stall_o  rdcw_pkg::in_item_t (cmd, value)
//   out      output     out_valid_o/out_stall_i rdcw_pkg::out_item_t (nine fields)
//   cfg      input      cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
// One beat per cycle while out does not stall; a beat passes the input register, then the result register.
// The input register and the result register each hold one beat, so a new beat
// is taken while a finished result waits. A stall on out backs up into in_stall_o
// once both registers are full. Reset clears all state at once; no clearing pass.
// Config writes are always taken (cfg_ready_o stays high); unknown indexes are dropped.
module remote_drive_command_watchdog (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  rdcw_pkg::in_item_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output rdcw_pkg::out_item_t               out_data_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rdcw_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [rdcw_pkg::CfgDataW-1:0]     cfg_data_i
);

  rdcw_pkg::cfg_t     cfg_q;
  logic               item_valid;
  logic               item_take;
  rdcw_pkg::in_item_t item;

  assign cfg_ready_o = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sleep_timeout_ms <= rdcw_pkg::SLEEP_TIMEOUT_RST;
      cfg_q.idle_timeout_ms  <= rdcw_pkg::IDLE_TIMEOUT_RST;
      cfg_q.front_led_code   <= rdcw_pkg::FRONT_LED_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        rdcw_pkg::CFG_SLEEP_TIMEOUT: cfg_q.sleep_timeout_ms <= cfg_data_i;
        rdcw_pkg::CFG_IDLE_TIMEOUT:  cfg_q.idle_timeout_ms  <= cfg_data_i;
        rdcw_pkg::CFG_FRONT_LED:     cfg_q.front_led_code   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  rdcw_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .item_valid_o (item_valid),
    .item_take_i  (item_take),
    .item_o       (item)
  );

  rdcw_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (item_valid),
    .item_take_o  (item_take),
    .item_i       (item),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== verif/remote_drive_command_watchdog_tb.sv =====
// Self-checking testbench for the remote drive command watchdog.
// A scoreboard class predicts the motor, lamp and mode status for every command beat.
// Depends on rdcw_pkg and remote_drive_command_watchdog.
module remote_drive_command_watchdog_tb;
  import rdcw_pkg::*;

  // Command codes that the block must treat as no-ops.
  localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;
  // Index beyond the register map; the write must be dropped.
  localparam logic [CfgIdxW-1:0] CFG_UNMAPPED = 2'd3;
  localparam logic [15:0] TIMEOUT_MAX  = 16'd65534;
  localparam logic [15:0] ELAPSED_SAT  = 16'hFFFF;
  localparam int unsigned LONG_HOLD    = 200;
  localparam int unsigned CYCLE_LIMIT  = 500000;

  // Predicts the status beat for each accepted command and checks the block's output.
  class motor_status_board;
    logic [15:0] sleep_limit;
    logic [15:0] idle_limit;
    logic [7:0]  led_code;
    logic [7:0]  left_pw;
    logic [7:0]  right_pw;
    mode_e       mode;
    logic [15:0] elapsed;
    dir_e        dir_l;
    dir_e        dir_r;
    logic [7:0]  mag_l;
    logic [7:0]  mag_r;
    logic        led;
    out_item_t   status_q[$];
    int unsigned errors;

    function new();
      sleep_limit = SLEEP_TIMEOUT_RST;
      idle_limit  = IDLE_TIMEOUT_RST;
      led_code    = FRONT_LED_RST;
      left_pw     = '0;
      right_pw    = '0;
      mode        = RUN_IDLE;
      elapsed     = '0;
      dir_l       = DIR_FREE;
      dir_r       = DIR_FREE;
      mag_l       = '0;
      mag_r       = '0;
      led         = 1'b0;
      errors      = 0;
    endfunction

    function void write_register(logic [CfgIdxW-1:0] idx, logic [15:0] data);
      case (idx)
        CFG_SLEEP_TIMEOUT: sleep_limit = data;
        CFG_IDLE_TIMEOUT:  idle_limit  = data;
        CFG_FRONT_LED:     led_code    = data[7:0];
        default: ;
      endcase
    endfunction

    // Direction and magnitude for one stored power; -128 clamps to 127.
    function void motor_for(input logic [7:0] pw, output dir_e d, output logic [7:0] m);
      logic [7:0] neg;
      neg = -pw;
      if (pw == 8'd0) begin
        d = DIR_FREE;
        m = 8'd0;
      end else if (pw[7]) begin
        d = DIR_REVERSE;
        m = (neg > 8'd127 || neg == 8'd0) ? 8'd127 : neg;
      end else begin
        d = DIR_FORWARD;
        m = pw;
      end
    endfunction

    function void resume_drive();
      motor_for(left_pw, dir_l, mag_l);
      motor_for(right_pw, dir_r, mag_r);
      mode = RUN_DRIVE;
    endfunction

    function void note_command(in_item_t beat);
      out_item_t st;
      logic      report;
      report = 1'b0;
      case (beat.cmd)
        CMD_TICK: begin
          if (elapsed != ELAPSED_SAT) elapsed = elapsed + 16'd1;
        end
        CMD_REFRESH: begin
          elapsed = '0;
          report  = 1'b1;
          if (mode == RUN_SLEEP) resume_drive();
        end
        CMD_LEFT: begin
          left_pw = beat.value;
          resume_drive();
        end
        CMD_RIGHT: begin
          right_pw = beat.value;
          resume_drive();
        end
        CMD_TOGGLE: begin
          if ($unsigned(beat.value) == led_code) led = ~led;
        end
        default: ;
      endcase

      // The watchdog runs after every command while driving.
      if (mode == RUN_DRIVE) begin
        if (elapsed > idle_limit) begin
          motor_for(8'd0, dir_l, mag_l);
          motor_for(8'd0, dir_r, mag_r);
          mode = RUN_IDLE;
        end else if (elapsed > sleep_limit) begin
          motor_for(8'd0, dir_l, mag_l);
          motor_for(8'd0, dir_r, mag_r);
          mode = RUN_SLEEP;
        end
      end

      st.left_direction  = dir_l;
      st.left_drive      = {mag_l[6:0], 1'b0};
      st.right_direction = dir_r;
      st.right_drive     = {mag_r[6:0], 1'b0};
      st.back_left_lamp  = (dir_l == DIR_REVERSE);
      st.back_right_lamp = (dir_r == DIR_REVERSE);
      st.front_lamp      = led;
      st.run_mode        = mode;
      st.report_request  = report;
      status_q.push_back(st);
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_status(out_item_t got);
      out_item_t want;
      if (status_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected status beat, expected none, actual %h", $time, got);
        return;
      end
      want = status_q.pop_front();
      compare_field("left_direction", 8'(want.left_direction), 8'(got.left_direction));
      compare_field("left_drive", want.left_drive, got.left_drive);
      compare_field("right_direction", 8'(want.right_direction), 8'(got.right_direction));
      compare_field("right_drive", want.right_drive, got.right_drive);
      compare_field("back_left_lamp", 8'(want.back_left_lamp), 8'(got.back_left_lamp));
      compare_field("back_right_lamp", 8'(want.back_right_lamp), 8'(got.back_right_lamp));
      compare_field("front_lamp", 8'(want.front_lamp), 8'(got.front_lamp));
      compare_field("run_mode", 8'(want.run_mode), 8'(got.run_mode));
      compare_field("report_request", 8'(want.report_request), 8'(got.report_request));
    endfunction

    function int pending();
      return status_q.size();
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [CfgDataW-1:0]  cfg_data;

  motor_status_board board = new();
  bit          idling_on;
  int unsigned hold_requests;
  int unsigned hold_served;
  int unsigned stall_left;
  int unsigned hold_left;
  int unsigned cycle_count;
  logic [15:0] cur_sleep;
  logic [15:0] cur_idle;
  logic [7:0]  cur_code;

  remote_drive_command_watchdog uut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit: a hung handshake or a lost beat ends here.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("remote_drive_command_watchdog_tb failed");
    $finish;
  end

  // Every status beat taken by the testbench is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_status(out_data);
  end

  // Receiver: random stall bursts, plus a long hold-off when the stimulus asks for one.
  initial begin
    out_stall   = 1'b0;
    hold_served = 0;
    stall_left  = 0;
    hold_left   = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one command beat and hold it until the block takes it.
  task automatic send_beat(input logic [2:0] cmd, input logic [7:0] value);
    in_item_t beat;
    int       gap;
    beat.cmd   = cmd;
    beat.value = value;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 10);
      repeat (gap) begin
        @(negedge clk);
        in_valid <= 1'b0;
      end
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    board.note_command(beat);
  endtask

  // Stop offering and wait until every predicted status beat has come back.
  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CfgIdxW-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.write_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [15:0] sleep_ms, input logic [15:0] idle_ms,
                           input logic [7:0] code);
    wait_for_drain();
    write_register(CFG_SLEEP_TIMEOUT, sleep_ms);
    write_register(CFG_IDLE_TIMEOUT, idle_ms);
    write_register(CFG_FRONT_LED, {8'd0, code});
    cur_sleep = sleep_ms;
    cur_idle  = idle_ms;
    cur_code  = code;
  endtask

  // Powers lean toward the extremes and zero.
  function automatic logic [7:0] pick_power();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd127;
      2: return 8'h80;
      3: return 8'hFF;
      4: return 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  // Random command sessions: tick runs that can trip the watchdog under short timeouts, updates,
  // speed changes and toggles, with some spare codes and plain noise mixed in.
  task automatic run_commands(input int unsigned count);
    int unsigned sent;
    int unsigned pick;
    int unsigned run_max;
    int unsigned run_len;
    sent    = 0;
    run_max = (cur_idle > cur_sleep) ? 2 * cur_idle + 4 : 2 * cur_sleep + 4;
    if (run_max > 40) run_max = 40;
    while (sent < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        run_len = $urandom_range(1, run_max);
        repeat (run_len) send_beat(CMD_TICK, 8'($urandom));
        sent += run_len;
      end else begin
        if (pick < 40)
          send_beat(CMD_REFRESH, 8'($urandom));
        else if (pick < 55)
          send_beat(CMD_LEFT, pick_power());
        else if (pick < 70)
          send_beat(CMD_RIGHT, pick_power());
        else if (pick < 85)
          send_beat(CMD_TOGGLE, ($urandom_range(0, 2) != 0) ? cur_code : 8'($urandom));
        else if (pick < 92)
          send_beat(CMD_TICK, 8'($urandom));
        else if (pick < 96)
          send_beat(3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)), 8'($urandom));
        else
          send_beat(3'($urandom_range(0, 7)), 8'($urandom));
        sent++;
      end
    end
  endtask

  initial begin
    logic [15:0] s_ms;
    logic [15:0] i_ms;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    idling_on     = 1'b1;
    hold_requests = 0;
    cur_sleep     = SLEEP_TIMEOUT_RST;
    cur_idle      = IDLE_TIMEOUT_RST;
    cur_code      = FRONT_LED_RST;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;

    // Directed checks at the reset configuration: toggles, updates, power extremes.
    send_beat(CMD_TOGGLE, 8'h00);
    send_beat(CMD_TOGGLE, 8'h55);
    send_beat(CMD_REFRESH, 8'h00);
    send_beat(CMD_LEFT, 8'd127);
    send_beat(CMD_RIGHT, 8'h80);
    send_beat(CMD_LEFT, 8'hFF);
    send_beat(CMD_RIGHT, 8'd1);
    send_beat(CMD_LEFT, 8'd0);
    send_beat(CMD_SPARE_FIRST, 8'h7F);
    send_beat(CMD_SPARE_LAST, 8'h80);
    send_beat(CMD_TICK, 8'hFF);
    send_beat(CMD_REFRESH, 8'h01);

    // Short timeouts: sleep, resume, and a speed command that falls back to idle at once.
    configure(16'd2, 16'd4, 8'hA5);
    write_register(CFG_UNMAPPED, 16'hFFFF);
    send_beat(CMD_RIGHT, 8'd0);
    send_beat(CMD_LEFT, 8'h81);
    repeat (4) send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_REFRESH, 8'h00);
    repeat (5) send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_LEFT, 8'd10);
    send_beat(CMD_TOGGLE, 8'hA5);
    send_beat(CMD_TOGGLE, 8'h00);

    // Random sessions over several settings, the extremes among them.
    for (int s = 0; s < 8; s++) begin
      idling_on = (s != 5);
      case (s)
        0: configure(16'd0, 16'd0, 8'hFF);
        1: configure(TIMEOUT_MAX, TIMEOUT_MAX, 8'($urandom));
        2: configure(16'($urandom_range(5, 20)), 16'($urandom_range(0, 4)), 8'($urandom));
        4: configure(16'd1, 16'd3, 8'h00);
        6: configure(16'($urandom_range(0, 15)), 16'($urandom_range(0, TIMEOUT_MAX)),
                     8'($urandom));
        default: begin
          s_ms = 16'($urandom_range(0, 15));
          i_ms = 16'($urandom_range(s_ms, 40));
          configure(s_ms, i_ms, 8'($urandom));
        end
      endcase
      run_commands(40);
      if (s == 3) hold_requests++;
      if (s == 5) wait_for_drain();
      run_commands(40);
    end

    // Last part, no idling: a long tick run under the widest timeouts keeps driving.
    idling_on = 1'b0;
    configure(TIMEOUT_MAX, TIMEOUT_MAX, 8'h3C);
    send_beat(CMD_REFRESH, 8'h00);
    send_beat(CMD_LEFT, 8'd100);
    send_beat(CMD_RIGHT, 8'hCE);
    repeat (40) send_beat(CMD_TICK, 8'($urandom));
    send_beat(CMD_LEFT, 8'd1);
    send_beat(CMD_REFRESH, 8'h00);
    send_beat(CMD_TICK, 8'h00);
    send_beat(CMD_TOGGLE, 8'h3C);

    wait_for_drain();
    repeat (10) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("remote_drive_command_watchdog_tb passed");
    else
      $display("remote_drive_command_watchdog_tb failed");
    $finish;
  end

endmodule

// ===== remote_drive_command_watchdog.f =====
hdl/rdcw_pkg.sv
hdl/rdcw_in_stage.sv
hdl/rdcw_step.sv
hdl/remote_drive_command_watchdog.sv
verif/remote_drive_command_watchdog_tb.sv
